/* design/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition at one edge implies a condition at the next edge
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* design/srba_pkg.sv */
// shared types, constants and functions of the scaler record bcd accumulator
package srba_pkg;

	localparam int CHANNELS       = 8;
	localparam int OUT_CHANNELS   = 8;
	localparam int TOTAL_BITS     = 48;
	localparam int SUM_BITS       = TOTAL_BITS + 1;
	localparam int OUT_TOTAL_BITS = 48;
	localparam int BCD_BITS       = 15;
	localparam int SCALED_BITS    = 28;
	localparam int DATA_WORDS     = 16;
	localparam int MIN_SUB_LEN    = 18;
	localparam int HIGH_SCALE     = 10000;

	localparam logic [4:0] CAP_IDLE      = 5'd0;
	localparam logic [4:0] CAP_FIRST     = 5'd1;
	localparam logic [4:0] CAP_LAST      = 5'd16;
	localparam logic [4:0] CAP_AWAIT_TAG = 5'd17;

	localparam logic [15:0] NO_HEADER      = 16'hFFFF;
	localparam logic [15:0] FIRST_HEADER   = 16'd1;
	localparam logic [15:0] RECORD_TAG_RST = 16'h4553;
	localparam logic [15:0] BLOCK_TAG_RST  = 16'h5653;
	localparam logic [15:0] MAX_WORDS_RST  = 16'd60000;

	localparam logic [11:0] BLOCK_COUNT_MAX = 12'hFFF;

	localparam logic [1:0] REG_RECORD_TAG = 2'd0;
	localparam logic [1:0] REG_BLOCK_TAG  = 2'd1;
	localparam logic [1:0] REG_MAX_WORDS  = 2'd2;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_HALT   = 2'd1;
	localparam logic [1:0] STATUS_FORMAT = 2'd2;

	typedef logic [TOTAL_BITS-1:0] total_t;
	typedef logic [SUM_BITS-1:0] total_sum_t;

	typedef struct packed {
		logic [15:0] data_word;
		logic        start_stream;
	} src_req_t;

	typedef struct packed {
		logic [47:0] total_ch1;
		logic [47:0] total_ch2;
		logic [47:0] total_ch3;
		logic [47:0] total_ch4;
		logic [47:0] total_ch5;
		logic [47:0] total_ch6;
		logic [47:0] total_ch7;
		logic [47:0] total_ch8;
		logic [11:0] blocks_in_record;
		logic [1:0]  status;
	} res_req_t;

	// four bcd digits, nibbles weighted by their plain value
	function automatic logic [BCD_BITS-1:0] bcd4(input logic [15:0] w);
		return BCD_BITS'(w[3:0])
			+ BCD_BITS'(w[7:4]) * BCD_BITS'(10)
			+ BCD_BITS'(w[11:8]) * BCD_BITS'(100)
			+ BCD_BITS'(w[15:12]) * BCD_BITS'(1000);
	endfunction

endpackage

/* design/scaler_record_bcd_accumulator.sv */
// top level of the scaler record bcd accumulator
// Usage:
// The src channel carries one 16-bit stream word per request, with start_stream
// marking the first word of a new file (framing restarts, totals are kept).
// The res channel carries one request at the end of every tagged record, and one
// when a record is too long: eight saturating channel totals, the number of
// scaler blocks in the record and a status (ok, record too long, sub-block format error).
// Both channels use valid/stall; a request moves when valid is high and stall low.
// Throughput: one word per cycle while res is not stalled; every word passes
// an input register, a bcd decode and scale stage, and one state update that
// does a single 48-bit add with saturation into the result register.
// When res is stalled with a result held, the pipeline freezes and src_stall
// rises until the result is taken.
// Reset clears the totals, all framing state and the halt flag, and loads the
// default tags and length limit. A too-long record halts the block until reset.
// Registers (APB, 32-bit words): 0x0 record tag, 0x4 block tag, 0x8 length limit.
module scaler_record_bcd_accumulator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  srba_pkg::src_req_t src_data,
	output logic              res_valid,
	input  logic              res_stall,
	output srba_pkg::res_req_t res_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import srba_pkg::*;

	logic [15:0] record_tag_q, block_tag_q, max_words_q;

	logic                   adv;
	logic                   valid_s1, start_s1;
	logic [15:0]            word_s1;
	logic                   valid_s2, start_s2;
	logic [15:0]            word_s2;
	logic [BCD_BITS-1:0]    bcd_s2;
	logic [SCALED_BITS-1:0] scaled_s2;
	logic [BCD_BITS-1:0]    bcd_s1;

	logic [15:0] word_pos_q, rec_len_q, next_hdr_q;
	logic        tagged_q, halted_q, fmt_err_q;
	logic [4:0]  cap_q;
	logic [14:0] low_q;
	logic [11:0] block_cnt_q;
	total_t      totals_q [CHANNELS];

	logic [15:0] word_pos_n, rec_len_n, next_hdr_n;
	logic        tagged_n, halted_n, fmt_err_n;
	logic [4:0]  cap_n;
	logic [14:0] low_n;
	logic [11:0] block_cnt_n;
	total_t      totals_n [CHANNELS];

	logic                   clear_e, emit, add_en;
	logic [1:0]             emit_status;
	logic [15:0]            last, p;
	logic [4:0]             j;
	logic [2:0]             ch;
	logic [SCALED_BITS-1:0] add_val;
	total_t                 t_sel;
	total_sum_t             t_sum;
	logic [16:0]            nh_sum;
	logic [OUT_TOTAL_BITS-1:0] out_tot [OUT_CHANNELS];
	res_req_t               res_n;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_tag_q <= RECORD_TAG_RST;
			block_tag_q  <= BLOCK_TAG_RST;
			max_words_q  <= MAX_WORDS_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_RECORD_TAG: record_tag_q <= pwdata[15:0];
				REG_BLOCK_TAG:  block_tag_q  <= pwdata[15:0];
				REG_MAX_WORDS:  max_words_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RECORD_TAG: prdata = {16'd0, record_tag_q};
			REG_BLOCK_TAG:  prdata = {16'd0, block_tag_q};
			REG_MAX_WORDS:  prdata = {16'd0, max_words_q};
			default:        prdata = 32'd0;
		endcase
	end

	// pipeline advance
	assign adv       = !res_valid || !res_stall;
	assign src_stall = !adv;
	assign bcd_s1    = bcd4(word_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= src_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (src_valid) begin
				word_s1  <= src_data.data_word;
				start_s1 <= src_data.start_stream;
			end
			word_s2   <= word_s1;
			start_s2  <= start_s1;
			bcd_s2    <= bcd_s1;
			scaled_s2 <= SCALED_BITS'(bcd_s1) * SCALED_BITS'(HIGH_SCALE);
		end
	end

	// record framing and accumulation
	always_comb begin
		clear_e     = valid_s2 && start_s2 && !halted_q;
		word_pos_n  = clear_e ? 16'd0 : word_pos_q;
		rec_len_n   = clear_e ? 16'd0 : rec_len_q;
		tagged_n    = clear_e ? 1'b0 : tagged_q;
		next_hdr_n  = clear_e ? FIRST_HEADER : next_hdr_q;
		cap_n       = clear_e ? CAP_IDLE : cap_q;
		low_n       = clear_e ? 15'd0 : low_q;
		block_cnt_n = clear_e ? 12'd0 : block_cnt_q;
		fmt_err_n   = clear_e ? 1'b0 : fmt_err_q;
		halted_n    = halted_q;
		totals_n    = totals_q;
		emit        = 1'b0;
		emit_status = STATUS_OK;
		add_en      = 1'b0;
		p           = word_pos_n;
		last        = rec_len_n - 16'd2;
		j           = cap_n - CAP_FIRST;
		ch          = j[3:1];
		add_val     = scaled_s2 + SCALED_BITS'(low_q);
		nh_sum      = 17'(p) + 17'(word_s2);
		t_sel       = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (ch == 3'(c))
				t_sel = totals_q[c];
		end
		t_sum = total_sum_t'(t_sel) + total_sum_t'(add_val);

		if (valid_s2 && !halted_q) begin
			if (rec_len_n == 16'd0) begin
				if (word_s2 > max_words_q) begin
					halted_n    = 1'b1;
					emit        = 1'b1;
					emit_status = STATUS_HALT;
				end else if (word_s2 >= 16'd2) begin
					rec_len_n  = word_s2;
					word_pos_n = 16'd0;
				end
			end else begin
				if (p == 16'd0) begin
					tagged_n = (word_s2 == record_tag_q);
				end else if (tagged_n) begin
					if (cap_n >= CAP_FIRST && cap_n <= CAP_LAST) begin
						if (!j[0])
							low_n = bcd_s2;
						else if (32'(ch) < CHANNELS)
							add_en = 1'b1;
						if (cap_n == CAP_LAST) begin
							cap_n = CAP_IDLE;
							if (block_cnt_n != BLOCK_COUNT_MAX)
								block_cnt_n = block_cnt_n + 12'd1;
						end else begin
							cap_n = cap_n + 5'd1;
						end
					end else if (cap_n == CAP_AWAIT_TAG) begin
						cap_n = (word_s2 == block_tag_q
							&& 17'(p) + 17'(DATA_WORDS) <= 17'(last)) ? CAP_FIRST : CAP_IDLE;
					end else if (p == next_hdr_n) begin
						if (word_s2 < 16'(MIN_SUB_LEN)) begin
							fmt_err_n  = 1'b1;
							next_hdr_n = NO_HEADER;
						end else begin
							next_hdr_n = nh_sum[16] ? NO_HEADER : nh_sum[15:0];
							cap_n      = CAP_AWAIT_TAG;
						end
					end
				end

				if (add_en) begin
					for (int c = 0; c < CHANNELS; c++) begin
						if (ch == 3'(c))
							totals_n[c] = t_sum[SUM_BITS-1] ? '1 : t_sum[TOTAL_BITS-1:0];
					end
				end

				if (p >= last) begin
					emit        = tagged_n;
					emit_status = fmt_err_n ? STATUS_FORMAT : STATUS_OK;
				end else begin
					word_pos_n = p + 16'd1;
				end
			end
		end

		for (int c = 0; c < OUT_CHANNELS; c++)
			out_tot[c] = '0;
		for (int c = 0; c < CHANNELS; c++)
			out_tot[c] = OUT_TOTAL_BITS'(totals_n[c]);

		res_n.total_ch1        = out_tot[0];
		res_n.total_ch2        = out_tot[1];
		res_n.total_ch3        = out_tot[2];
		res_n.total_ch4        = out_tot[3];
		res_n.total_ch5        = out_tot[4];
		res_n.total_ch6        = out_tot[5];
		res_n.total_ch7        = out_tot[6];
		res_n.total_ch8        = out_tot[7];
		res_n.blocks_in_record = block_cnt_n;
		res_n.status           = emit_status;

		// end of record clears framing
		if (valid_s2 && !halted_q && rec_len_n != 16'd0 && p >= last) begin
			word_pos_n  = 16'd0;
			rec_len_n   = 16'd0;
			tagged_n    = 1'b0;
			next_hdr_n  = FIRST_HEADER;
			cap_n       = CAP_IDLE;
			low_n       = 15'd0;
			block_cnt_n = 12'd0;
			fmt_err_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_pos_q  <= 16'd0;
			rec_len_q   <= 16'd0;
			tagged_q    <= 1'b0;
			next_hdr_q  <= FIRST_HEADER;
			cap_q       <= CAP_IDLE;
			low_q       <= 15'd0;
			block_cnt_q <= 12'd0;
			halted_q    <= 1'b0;
			fmt_err_q   <= 1'b0;
			for (int c = 0; c < CHANNELS; c++)
				totals_q[c] <= '0;
			res_valid   <= 1'b0;
		end else if (adv) begin
			word_pos_q  <= word_pos_n;
			rec_len_q   <= rec_len_n;
			tagged_q    <= tagged_n;
			next_hdr_q  <= next_hdr_n;
			cap_q       <= cap_n;
			low_q       <= low_n;
			block_cnt_q <= block_cnt_n;
			halted_q    <= halted_n;
			fmt_err_q   <= fmt_err_n;
			totals_q    <= totals_n;
			res_valid   <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit)
			res_data <= res_n;
	end

endmodule

/* design/srba_chk.sv */
// port-level checker for the scaler record bcd accumulator, with its bind
module srba_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              src_valid,
	input logic              src_stall,
	input srba_pkg::src_req_t src_data,
	input logic              res_valid,
	input logic              res_stall,
	input srba_pkg::res_req_t res_data,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [3:0]        paddr,
	input logic [31:0]       pwdata,
	input logic [31:0]       prdata,
	input logic              pready
);
	import srba_pkg::*;

`include "assert_macros.svh"

	// a held result stays put
	`ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_data), "result changed while stalled")

	// input is only held back by a blocked result
	`ASSERT_ALWAYS(a_stall_cause, !src_stall || (res_valid && res_stall), "src stalled without blocked result")

	// status code never takes the unused value
	`ASSERT_ALWAYS(a_status_code, !res_valid || res_data.status == STATUS_OK || res_data.status == STATUS_HALT || res_data.status == STATUS_FORMAT, "bad status code")

	// after a halt result is taken, res_valid drops
	`ASSERT_NEXT(a_halt_quiet, res_valid && !res_stall && res_data.status == STATUS_HALT, !res_valid, "result after halt")

endmodule

bind scaler_record_bcd_accumulator srba_chk u_srba_chk (.*);
